// ===== src/s5rp_pkg.sv =====
package s5rp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PORT_W  = 16;

    localparam logic [BYTE_W-1:0] SOCKS_VER    = 8'h05;
    localparam logic [BYTE_W-1:0] SOCKS_REP_OK = 8'h00;
    localparam logic [BYTE_W-1:0] ATYP_IPV4    = 8'h01;
    localparam logic [BYTE_W-1:0] ATYP_DOMAIN  = 8'h03;
    localparam logic [BYTE_W-1:0] ATYP_IPV6    = 8'h04;

    localparam logic [COUNT_W-1:0] POS_VER       = 9'd0;
    localparam logic [COUNT_W-1:0] POS_REP       = 9'd1;
    localparam logic [COUNT_W-1:0] POS_ATYP      = 9'd3;
    localparam logic [COUNT_W-1:0] POS_ADDR      = 9'd4;
    localparam logic [COUNT_W-1:0] POS_ADDR_LAST = 9'd7;
    localparam logic [COUNT_W-1:0] POS_PORT_HI   = 9'd8;
    localparam logic [COUNT_W-1:0] POS_PORT_LO   = 9'd9;
    localparam logic [COUNT_W-1:0] MIN_DONE      = 9'd5;
    localparam logic [COUNT_W-1:0] HDR_TRAIL     = 9'd6;
    localparam logic [COUNT_W-1:0] LEN_IPV4      = 9'd4;
    localparam logic [COUNT_W-1:0] LEN_IPV6      = 9'd16;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_HDR   = 2'd1,
        ST_BAD_ATYP  = 2'd2
    } t_status;

    typedef struct packed {
        logic              done_res;
        t_status           status;
        logic [ADDR_W-1:0] ipv4_addr;
        logic [PORT_W-1:0] bound_port;
    } t_result;

endpackage

// ===== src/s5rp_in_stage.sv =====
module s5rp_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [s5rp_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                        i_take,
    output logic                        o_in_stall,
    output logic                        o_valid,
    output logic [s5rp_pkg::BYTE_W-1:0] o_byte
);
    import s5rp_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              accept;

    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_valid    = accept || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== src/s5rp_core.sv =====
module s5rp_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [s5rp_pkg::BYTE_W-1:0] i_byte,
    output s5rp_pkg::t_result           o_result
);
    import s5rp_pkg::*;

    logic [COUNT_W-1:0] r_byte_count;
    logic               r_header_ok;
    logic [BYTE_W-1:0]  r_addr_kind;
    logic [COUNT_W-1:0] r_addr_len;
    logic [ADDR_W-1:0]  r_addr_shift;
    logic [PORT_W-1:0]  r_port_shift;

    logic [COUNT_W-1:0] n_byte_count;
    logic               n_header_ok;
    logic [BYTE_W-1:0]  n_addr_kind;
    logic [COUNT_W-1:0] n_addr_len;
    logic [ADDR_W-1:0]  n_addr_shift;
    logic [PORT_W-1:0]  n_port_shift;

    logic               bad_atyp;
    logic               complete;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] hdr_ok_upd;
    logic [COUNT_W-1:0] end_count;
    logic               hdr_ok;
    logic [BYTE_W-1:0]  kind;
    logic [COUNT_W-1:0] len;
    logic [ADDR_W-1:0]  addr_upd;
    logic [PORT_W-1:0]  port_upd;

    always_comb begin
        hdr_ok = r_header_ok;
        if (r_byte_count == POS_VER && i_byte != SOCKS_VER) begin
            hdr_ok = 1'b0;
        end
        if (r_byte_count == POS_REP && i_byte != SOCKS_REP_OK) begin
            hdr_ok = 1'b0;
        end
        kind = (r_byte_count == POS_ATYP) ? i_byte : r_addr_kind;

        len      = r_addr_len;
        bad_atyp = 1'b0;
        if (r_byte_count == POS_ADDR) begin
            unique case (kind)
                ATYP_IPV4:   len = LEN_IPV4;
                ATYP_DOMAIN: len = {1'b0, i_byte} + 9'd1;
                ATYP_IPV6:   len = LEN_IPV6;
                default:     bad_atyp = 1'b1;
            endcase
        end

        addr_upd = r_addr_shift;
        if (r_byte_count >= POS_ADDR && r_byte_count <= POS_ADDR_LAST) begin
            addr_upd = {r_addr_shift[ADDR_W-BYTE_W-1:0], i_byte};
        end
        port_upd = r_port_shift;
        if (r_byte_count == POS_PORT_HI || r_byte_count == POS_PORT_LO) begin
            port_upd = {r_port_shift[PORT_W-BYTE_W-1:0], i_byte};
        end

        count_inc  = r_byte_count + 9'd1;
        end_count  = HDR_TRAIL + len;
        hdr_ok_upd = count_inc;
        complete   = !bad_atyp && (count_inc >= MIN_DONE) && (hdr_ok_upd == end_count);
    end

    always_comb begin
        o_result = '0;
        if (bad_atyp) begin
            o_result.done_res = 1'b1;
            o_result.status   = ST_BAD_ATYP;
        end else if (complete) begin
            o_result.done_res = 1'b1;
            if (hdr_ok) begin
                o_result.status = ST_OK;
                if (kind == ATYP_IPV4) begin
                    o_result.ipv4_addr  = addr_upd;
                    o_result.bound_port = port_upd;
                end
            end else begin
                o_result.status = ST_BAD_HDR;
            end
        end
    end

    always_comb begin
        if (bad_atyp || complete) begin
            n_byte_count = '0;
            n_header_ok  = 1'b1;
            n_addr_kind  = '0;
            n_addr_len   = '0;
            n_addr_shift = '0;
            n_port_shift = '0;
        end else begin
            n_byte_count = count_inc;
            n_header_ok  = hdr_ok;
            n_addr_kind  = kind;
            n_addr_len   = len;
            n_addr_shift = addr_upd;
            n_port_shift = port_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_header_ok  <= 1'b1;
            r_addr_kind  <= '0;
            r_addr_len   <= '0;
            r_addr_shift <= '0;
            r_port_shift <= '0;
        end else if (i_fire) begin
            r_byte_count <= n_byte_count;
            r_header_ok  <= n_header_ok;
            r_addr_kind  <= n_addr_kind;
            r_addr_len   <= n_addr_len;
            r_addr_shift <= n_addr_shift;
            r_port_shift <= n_port_shift;
        end
    end

endmodule

// ===== src/s5rp_out_stage.sv =====
module s5rp_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  s5rp_pkg::t_result  i_result,
    input  logic               i_out_stall,
    output logic               o_ready,
    output logic               o_valid,
    output s5rp_pkg::t_result  o_result
);
    import s5rp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_ready = !r_valid || !i_out_stall;
    assign n_valid = i_load || (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== src/socks5_reply_parser.sv =====
// SOCKS5 server reply parser.
// Input channel: i_in_valid / o_in_stall carry one reply byte (i_rx_byte) per
// transfer. Output channel: o_out_valid / i_out_stall carry one result per
// input byte: o_done_res, o_status, o_ipv4_addr, o_bound_port.
// A result is all zero until the byte that completes or rejects a reply; that
// byte gives o_done_res = 1 with the status (0 success, 1 bad version or reply
// code, 2 unknown address type), and the parser is ready for the next reply.
// Address and port are nonzero only for a successful IPv4 reply.
// Path: a transferred byte goes into the input register, through the parse
// logic, and into the result register. Throughput: one byte per cycle while
// i_out_stall is low, set by the single pass from the input register through
// the parse logic to the result register.
// Reset (synchronous, i_rst_n low) empties both registers and returns the
// parser to the start of a reply.
// While i_out_stall holds, a full result register keeps its contents; the input
// register takes one more byte and then o_in_stall rises until the result
// is taken.
module socks5_reply_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [s5rp_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_done_res,
    output logic [1:0]                  o_status,
    output logic [s5rp_pkg::ADDR_W-1:0] o_ipv4_addr,
    output logic [s5rp_pkg::PORT_W-1:0] o_bound_port
);
    import s5rp_pkg::*;

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              out_ready;
    logic              fire;
    t_result           next_result;
    t_result           out_result;

    assign fire = in_valid && out_ready;

    s5rp_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .i_take     (fire),
        .o_in_stall (o_in_stall),
        .o_valid    (in_valid),
        .o_byte     (in_byte)
    );

    s5rp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (in_byte),
        .o_result (next_result)
    );

    s5rp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_result    (next_result),
        .i_out_stall (i_out_stall),
        .o_ready     (out_ready),
        .o_valid     (o_out_valid),
        .o_result    (out_result)
    );

    assign o_done_res   = out_result.done_res;
    assign o_status     = out_result.status;
    assign o_ipv4_addr  = out_result.ipv4_addr;
    assign o_bound_port = out_result.bound_port;

    a_not_done_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |->
            (o_status == ST_OK && o_ipv4_addr == '0 && o_bound_port == '0))
        else $error("non-final result carries data");

    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_ipv4_addr == '0 && o_bound_port == '0))
        else $error("rejected reply carries address or port");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_BAD_HDR ||
                         o_status == ST_BAD_ATYP))
        else $error("status code out of range");

    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while result register can advance");

endmodule
